// ===== design/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies. Used by the front, queue, back and top-level modules.
package mcr_pkg;

	localparam int COORD_BITS_DEF = 16;  // default coordinate wrap width
	localparam int PIX_W          = 16;  // pixel coordinate port width
	localparam int RES_W          = 13;  // resolution register width
	localparam int ADDR_W         = 24;  // byte address width
	localparam int COLOR_W        = 8;
	localparam int RADIUS_W       = 16;
	localparam int OX_W           = 18;  // signed x offset
	localparam int OY_W           = 17;  // y offset, never negative
	localparam int STEP_W         = 18;  // dx / dy increments
	localparam int ERR_W          = 21;  // signed midpoint error

	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	// register indexes (paddr[2])
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [RES_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [RES_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// octant counter: eighth pixel closes a step
	localparam logic [2:0] OCT_LAST = 3'd7;

	// one step worth of pixels, handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0]   center_col;
		logic [PIX_W-1:0]   center_row;
		logic [COLOR_W-1:0] colour;
		logic [PIX_W-1:0]   x_low;   // low bits of offset x (two's complement)
		logic [PIX_W-1:0]   y_low;
		logic               done;    // walk ends with this step
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ===== design/mcr_front.sv =====
// Front end: takes start/step requests, runs the midpoint error walk and
// pushes one job per productive step. Depends on mcr_pkg.
module mcr_front import mcr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                command,
	input  logic [PIX_W-1:0]    center_x,
	input  logic [PIX_W-1:0]    center_y,
	input  logic [RADIUS_W-1:0] radius,
	input  logic [COLOR_W-1:0]  colour,
	output logic                push,
	output job_t                job
);

	localparam logic [PIX_W-1:0] CMASK = PIX_W'((32'd1 << COORD_BITS) - 32'd1);

	logic [PIX_W-1:0]        center_col_q, center_row_q;
	logic [RADIUS_W-1:0]     radius_q;
	logic [COLOR_W-1:0]      colour_q;
	logic signed [OX_W-1:0]  x_q;
	logic [OY_W-1:0]         y_q;
	logic [STEP_W-1:0]       dx_q, dy_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    active_q;

	logic signed [OX_W-1:0]  x_nx;
	logic [OY_W-1:0]         y_nx;
	logic [STEP_W-1:0]       dx_nx, dy_nx;
	logic signed [ERR_W-1:0] e_mid, e_nx;
	logic                    active_nx;

	// midpoint update: y move first, then x move on the updated error
	always_comb begin
		y_nx  = y_q;
		dy_nx = dy_q;
		e_mid = err_q;
		if (err_q <= ERR_W'(0)) begin
			y_nx  = y_q + OY_W'(1);
			e_mid = err_q + $signed(ERR_W'(dy_q));
			dy_nx = dy_q + STEP_W'(2);
		end
		x_nx  = x_q;
		dx_nx = dx_q;
		e_nx  = e_mid;
		if (e_mid > $signed(ERR_W'(0))) begin
			x_nx  = x_q - $signed(OX_W'(1));
			dx_nx = dx_q + STEP_W'(2);
			e_nx  = e_mid + $signed(ERR_W'(dx_nx)) - $signed(ERR_W'({radius_q, 1'b0}));
		end
		active_nx = x_nx >= $signed(OX_W'(y_nx));
	end

	assign push = accept && (command == CMD_STEP) && active_q;

	always_comb begin
		job.center_col = center_col_q;
		job.center_row = center_row_q;
		job.colour     = colour_q;
		job.x_low      = PIX_W'(x_q);
		job.y_low      = PIX_W'(y_q);
		job.done       = !active_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= '0;
			colour_q     <= '0;
			x_q          <= '0;
			y_q          <= '0;
			dx_q         <= STEP_W'(1);
			dy_q         <= STEP_W'(1);
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (accept) begin
			if (command == CMD_START) begin
				center_col_q <= center_x & CMASK;
				center_row_q <= center_y & CMASK;
				radius_q     <= radius;
				colour_q     <= colour;
				x_q          <= $signed(OX_W'(radius)) - $signed(OX_W'(1));
				y_q          <= '0;
				dx_q         <= STEP_W'(1);
				dy_q         <= STEP_W'(1);
				err_q        <= $signed(ERR_W'(1)) - $signed(ERR_W'({radius, 1'b0}));
				active_q     <= radius != '0;
			end else if (active_q) begin
				x_q      <= x_nx;
				y_q      <= y_nx;
				dx_q     <= dx_nx;
				dy_q     <= dy_nx;
				err_q    <= e_nx;
				active_q <= active_nx;
			end
		end
	end

endmodule

// ===== design/mcr_queue.sv =====
// Short job queue between front and back ends.
// Depends on mcr_pkg (job_t, q_status_t, depth constants).
module mcr_queue import mcr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      wr_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.empty = count_q == '0;
	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/mcr_back.sv =====
// Back end: walks the head job's 8 octants, one pixel a cycle unless stalled,
// then forms address and clip flag in the output register. Depends on mcr_pkg.
module mcr_back import mcr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  job_t               head,
	input  q_status_t          q_status,
	output logic               pop,
	input  logic [RES_W-1:0]   screen_width,
	input  logic [RES_W-1:0]   screen_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [ADDR_W-1:0]  byte_address,
	output logic [COLOR_W-1:0] pixel_value,
	output logic               visible,
	output logic               last_of_step,
	output logic               circle_done
);

	localparam logic [PIX_W-1:0] CMASK = PIX_W'((32'd1 << COORD_BITS) - 32'd1);
	localparam int PROD_W = PIX_W + RES_W;

	logic [2:0]         oct_q;
	logic               gen_fire, s1_adv, out_adv;
	logic [PIX_W-1:0]   ox, oy, nx, ny;

	logic               valid_s1;
	logic [PIX_W-1:0]   px_s1, py_s1;
	logic [COLOR_W-1:0] val_s1;
	logic               last_s1, done_s1;

	logic               out_valid_q;
	logic [PROD_W-1:0]  prod;

	assign out_adv  = !out_valid_q || !out_stall;
	assign s1_adv   = !valid_s1 || out_adv;
	assign gen_fire = !q_status.empty && s1_adv;
	assign pop      = gen_fire && (oct_q == OCT_LAST);

	assign nx = PIX_W'(0) - head.x_low;
	assign ny = PIX_W'(0) - head.y_low;

	always_comb begin
		unique case (oct_q)
			3'd0: begin ox = head.x_low; oy = head.y_low; end
			3'd1: begin ox = head.y_low; oy = head.x_low; end
			3'd2: begin ox = ny;         oy = head.x_low; end
			3'd3: begin ox = nx;         oy = head.y_low; end
			3'd4: begin ox = nx;         oy = ny;         end
			3'd5: begin ox = ny;         oy = nx;         end
			3'd6: begin ox = head.y_low; oy = nx;         end
			3'd7: begin ox = head.x_low; oy = ny;         end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (gen_fire)
				oct_q <= oct_q + 3'd1;
			if (s1_adv)
				valid_s1 <= gen_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			px_s1   <= (head.center_col + ox) & CMASK;
			py_s1   <= (head.center_row + oy) & CMASK;
			val_s1  <= head.colour;
			last_s1 <= oct_q == OCT_LAST;
			done_s1 <= (oct_q == OCT_LAST) && head.done;
		end
	end

	assign prod = PROD_W'(py_s1) * PROD_W'(screen_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			pixel_x      <= px_s1;
			pixel_y      <= py_s1;
			byte_address <= ADDR_W'(prod + PROD_W'(px_s1));
			pixel_value  <= val_s1;
			visible      <= (px_s1 < PIX_W'(screen_width)) && (py_s1 < PIX_W'(screen_height));
			last_of_step <= last_s1;
			circle_done  <= done_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer top level: APB registers, front end, job queue, back end.
// Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
// Start requests give no pixels. A step on a live walk yields eight pixels,
// one per cycle unless the output stalls; the single pixel output port sets that rate.
// A step's job passes the job queue, the octant-walk register and the output register.
// arst_n clears all control state; screen size resets to 1024 x 768.
module midpoint_circle_rasterizer import mcr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [PIX_W-1:0]      center_x,
	input  logic [PIX_W-1:0]      center_y,
	input  logic [RADIUS_W-1:0]   radius,
	input  logic [COLOR_W-1:0]    colour,
	// pixel channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_x,
	output logic [PIX_W-1:0]      pixel_y,
	output logic [ADDR_W-1:0]     byte_address,
	output logic [COLOR_W-1:0]    pixel_value,
	output logic                  visible,
	output logic                  last_of_step,
	output logic                  circle_done
);

	logic [RES_W-1:0] screen_width_q, screen_height_q;
	logic             reg_wr;
	logic             accept, push, pop;
	job_t             new_job, head_job;
	q_status_t        q_status;

	// ---- configuration registers ----
	// Register index is paddr[2]; writes land on the access phase.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[RES_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[RES_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(screen_height_q);
		endcase
	end

	// ---- front end ----
	// Requests are held off only while the job queue is full; a full queue
	// means the back end still owes at least one whole step.
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	mcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.colour   (colour),
		.push     (push),
		.job      (new_job)
	);

	// ---- job queue ----
	// Each job carries its own center and colour, so a new start can proceed
	// in the front while older steps drain in the back.
	mcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (new_job),
		.pop    (pop),
		.head   (head_job),
		.status (q_status)
	);

	// ---- back end ----
	// Octant walk, then address multiply and clip in the output register,
	// which also decouples the pixel consumer's stall.
	mcr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head_job),
		.q_status      (q_status),
		.pop           (pop),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.byte_address  (byte_address),
		.pixel_value   (pixel_value),
		.visible       (visible),
		.last_of_step  (last_of_step),
		.circle_done   (circle_done)
	);

endmodule

// ===== design/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasterizer, bound to the top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer.
module mcr_checker import mcr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               out_valid,
	input logic               out_stall,
	input logic [PIX_W-1:0]   pixel_x,
	input logic [PIX_W-1:0]   pixel_y,
	input logic [ADDR_W-1:0]  byte_address,
	input logic               last_of_step,
	input logic               circle_done
);

	// stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(byte_address) && $stable(last_of_step) && $stable(circle_done))
		else $error("stalled pixel changed");

	// done only on the closing pixel of a step
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && circle_done |-> last_of_step)
		else $error("circle_done without last_of_step");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// no pixel comes out of reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid during reset");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_x      (pixel_x),
	.pixel_y      (pixel_y),
	.byte_address (byte_address),
	.last_of_step (last_of_step),
	.circle_done  (circle_done)
);

// ===== bench/midpoint_circle_rasterizer_tb.sv =====
// Self-checking bench for midpoint_circle_rasterizer: directed and random circle requests,
// APB screen-size changes, random pixel-channel stalls and request gaps, checked against a predictor.
// Depends on mcr_pkg and the midpoint_circle_rasterizer RTL.
module midpoint_circle_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcr_pkg::*;

	localparam int CLK_HALF       = 6;     // 12 ns period
	localparam int RESET_CYCLES   = 7;
	localparam int HOLD_CYCLES    = 300;   // long sink hold-off, fills the block
	localparam int SETTLE_CYCLES  = 16;    // margin after the last owed pixel
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or pixel moving
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 70;

	// one pixel write as seen on the output channel
	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic               vis;
		logic               last;
		logic               done;
	} pixel_t;

	// Predictor of the octant walk plus the queue of pixels still owed by the block.
	class circle_scoreboard;
		logic [RES_W-1:0]    width_reg;
		logic [RES_W-1:0]    height_reg;
		logic [PIX_W-1:0]    ctr_col;
		logic [PIX_W-1:0]    ctr_row;
		logic [RADIUS_W-1:0] rad;
		logic [COLOR_W-1:0]  col;
		int                  off_x, off_y, inc_x, inc_y, err;
		bit                  running;
		pixel_t              pixel_fifo[$];
		int                  mismatches, pixels_checked, hidden_pixels;
		int                  circles_closed, steps_taken;

		function new();
			width_reg      = SCREEN_WIDTH_RST;
			height_reg     = SCREEN_HEIGHT_RST;
			ctr_col        = '0;
			ctr_row        = '0;
			rad            = '0;
			col            = '0;
			off_x          = 0;
			off_y          = 0;
			inc_x          = 1;
			inc_y          = 1;
			err            = 0;
			running        = 1'b0;
			mismatches     = 0;
			pixels_checked = 0;
			hidden_pixels  = 0;
			circles_closed = 0;
			steps_taken    = 0;
		endfunction

		function void set_screen(logic reg_idx, logic [RES_W-1:0] value);
			if (reg_idx == REG_SCREEN_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// offsets wrap into the 16-bit coordinate space
		function void push_pixel(int ox, int oy, bit last, bit done);
			pixel_t      p;
			logic [47:0] a;
			p.px    = ctr_col + ox[PIX_W-1:0];
			p.py    = ctr_row + oy[PIX_W-1:0];
			a       = {32'b0, p.py} * {35'b0, width_reg} + {32'b0, p.px};
			p.addr  = a[ADDR_W-1:0];
			p.value = col;
			p.vis   = (p.px < width_reg) && (p.py < height_reg);
			p.last  = last;
			p.done  = done;
			pixel_fifo.push_back(p);
		endfunction

		// returns how many pixels the request should produce
		function int note_request(logic cmd, logic [PIX_W-1:0] cx, logic [PIX_W-1:0] cy,
				logic [RADIUS_W-1:0] r, logic [COLOR_W-1:0] c);
			int x, y, two_r;
			if (cmd == CMD_START) begin
				ctr_col = cx;
				ctr_row = cy;
				rad     = r;
				col     = c;
				off_x   = int'(r) - 1;
				off_y   = 0;
				inc_x   = 1;
				inc_y   = 1;
				err     = 1 - 2 * int'(r);
				running = off_x >= off_y;
				return 0;
			end
			if (!running)
				return 0;
			x     = off_x;
			y     = off_y;
			two_r = 2 * int'(rad);
			if (err <= 0) begin
				off_y++;
				err   += inc_y;
				inc_y += 2;
			end
			if (err > 0) begin
				off_x--;
				inc_x += 2;
				err   += inc_x - two_r;
			end
			running = off_x >= off_y;
			push_pixel( x,  y, 1'b0, 1'b0);
			push_pixel( y,  x, 1'b0, 1'b0);
			push_pixel(-y,  x, 1'b0, 1'b0);
			push_pixel(-x,  y, 1'b0, 1'b0);
			push_pixel(-x, -y, 1'b0, 1'b0);
			push_pixel(-y, -x, 1'b0, 1'b0);
			push_pixel( y, -x, 1'b0, 1'b0);
			push_pixel( x, -y, 1'b1, !running);
			steps_taken++;
			if (!running)
				circles_closed++;
			return 8;
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			string  bad;
			if (pixel_fifo.size() == 0) begin
				flag($sformatf("unexpected pixel x=%0d y=%0d", got.px, got.py));
				return;
			end
			want = pixel_fifo.pop_front();
			pixels_checked++;
			if (!want.vis)
				hidden_pixels++;
			bad = "";
			if (got.px !== want.px)       bad = {bad, " pixel_x"};
			if (got.py !== want.py)       bad = {bad, " pixel_y"};
			if (got.addr !== want.addr)   bad = {bad, " byte_address"};
			if (got.value !== want.value) bad = {bad, " pixel_value"};
			if (got.vis !== want.vis)     bad = {bad, " visible"};
			if (got.last !== want.last)   bad = {bad, " last_of_step"};
			if (got.done !== want.done)   bad = {bad, " circle_done"};
			if (bad != "")
				flag($sformatf({"%s: exp x=%0d y=%0d a=%h v=%h vis=%b l=%b d=%b,",
					" got x=%0d y=%0d a=%h v=%h vis=%b l=%b d=%b"}, bad,
					want.px, want.py, want.addr, want.value, want.vis, want.last, want.done,
					got.px, got.py, got.addr, got.value, got.vis, got.last, got.done));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid, in_stall;
	logic                  command;
	logic [PIX_W-1:0]      center_x, center_y;
	logic [RADIUS_W-1:0]   radius;
	logic [COLOR_W-1:0]    colour;
	logic                  out_valid, out_stall;
	logic [PIX_W-1:0]      pixel_x, pixel_y;
	logic [ADDR_W-1:0]     byte_address;
	logic [COLOR_W-1:0]    pixel_value;
	logic                  visible, last_of_step, circle_done;

	circle_scoreboard sb = new();

	int stall_pct;        // chance per cycle that the sink stalls
	int gap_pct;          // chance that the source idles before a request
	bit hold_off;         // raised by the sequencer, cleared by the sink after the hold
	int idle_cycles;
	int total_requests;
	int counted_items;    // starts and steps that produce pixels

	midpoint_circle_rasterizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.colour       (colour),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_value  (pixel_value),
		.visible      (visible),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Pixel monitor: every accepted pixel is matched against the oldest prediction.
	always @(posedge clk) begin
		pixel_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{pixel_x, pixel_y, byte_address, pixel_value, visible, last_of_step,
				circle_done};
			sb.check_pixel(seen);
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("midpoint_circle_rasterizer_tb NOT OK");
			$finish;
		end
	end

	// Pixel sink. Random stalls at stall_pct, now and then a stall burst, and
	// one long hold-off on request so the internal queue fills and in_stall rises.
	initial begin : pixel_sink
		int r;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2 && stall_pct > 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(20, 60)) @(posedge clk);
					out_stall <= 1'b0;
				end else begin
					out_stall <= (r < stall_pct);
				end
			end
		end
	end

	// APB write: setup cycle, access cycle, then back to idle.
	task automatic write_reg(input logic idx, input logic [RES_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(APB_DATA_W-RES_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_screen(idx, value);
		@(posedge clk);
	endtask

	// APB read-back; prdata is sampled at the access edge
	task automatic check_reg(input logic idx, input logic [RES_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DATA_W-RES_W){1'b0}}, value})
			sb.flag($sformatf("register %0d read %h, expected %h", idx, prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_screen(input logic [RES_W-1:0] w, input logic [RES_W-1:0] h);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		check_reg(REG_SCREEN_WIDTH, w);
		check_reg(REG_SCREEN_HEIGHT, h);
	endtask

	// Offers one request, optionally after an idle gap, and returns at the accept edge.
	task automatic send_request(input logic cmd, input logic [PIX_W-1:0] cx,
			input logic [PIX_W-1:0] cy, input logic [RADIUS_W-1:0] r,
			input logic [COLOR_W-1:0] c);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < gap_pct)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		center_x <= cx;
		center_y <= cy;
		radius   <= r;
		colour   <= c;
		do @(posedge clk); while (in_stall);
		total_requests++;
		if (sb.note_request(cmd, cx, cy, r, c) > 0 || cmd == CMD_START)
			counted_items++;
	endtask

	task automatic step_request();
		send_request(CMD_STEP, PIX_W'($urandom), PIX_W'($urandom), RADIUS_W'($urandom),
			COLOR_W'($urandom));
	endtask

	// Wait for every owed pixel, then let a step with no pixels finish too.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pixel_fifo.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed circles: a start followed by a run of steps, often to the end.
	// About one pick in ten is a stray step, which may land on an idle walker.
	task automatic random_circles(input int target);
		int                  first, pick, steps;
		logic [RADIUS_W-1:0] r;
		logic [PIX_W-1:0]    cx, cy;
		first = total_requests;
		while (total_requests - first < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				step_request();
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5)
				r = '0;
			else if (pick < 12)
				r = RADIUS_W'($urandom);      // any radius; walk is cut short below
			else if (pick < 22)
				r = RADIUS_W'($urandom_range(1, 3));
			else
				r = RADIUS_W'($urandom_range(4, 40));
			// half the centers near the visible area, half anywhere
			if ($urandom_range(0, 1)) begin
				cx = PIX_W'($urandom);
				cy = PIX_W'($urandom);
			end else begin
				cx = PIX_W'($urandom_range(0, int'(sb.width_reg) + 16));
				cy = PIX_W'($urandom_range(0, int'(sb.height_reg) + 16));
			end
			send_request(CMD_START, cx, cy, r, COLOR_W'($urandom));
			steps = (r > 200) ? $urandom_range(1, 6) : $urandom_range(1, int'(r) + 4);
			repeat (steps) step_request();
		end
	endtask

	initial begin : sequencer
		int phase_w[6]  = '{0, 1024, 1, 4096, 8191, 640};
		int phase_h[6]  = '{768, 0, 1, 4096, 8191, 480};
		int phase_st[6] = '{30, 0, 50, 10, 0, 25};
		int phase_gp[6] = '{30, 0, 60, 20, 10, 40};

		// every input known from time zero
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		in_valid       <= 1'b0;
		command        <= CMD_START;
		center_x       <= '0;
		center_y       <= '0;
		radius         <= '0;
		colour         <= '0;
		hold_off       = 1'b0;
		stall_pct      = 20;
		gap_pct        = 20;
		total_requests = 0;
		counted_items  = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the screen registers
		check_reg(REG_SCREEN_WIDTH, SCREEN_WIDTH_RST);
		check_reg(REG_SCREEN_HEIGHT, SCREEN_HEIGHT_RST);

		// directed: step with no circle, zero radius, unit circle at the origin
		// (all offsets are zero, done on the first step), step after done
		send_request(CMD_STEP, 16'h1234, 16'h5678, 16'd9, 8'h11);
		send_request(CMD_START, 16'd5, 16'd5, 16'd0, 8'h5A);
		step_request();
		send_request(CMD_START, 16'd0, 16'd0, 16'd1, 8'hFF);
		step_request();
		step_request();
		// small circle walked to its end
		send_request(CMD_START, 16'd100, 16'd200, 16'd3, 8'h00);
		repeat (4) step_request();
		// all-ones center and radius
		send_request(CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hAA);
		repeat (3) step_request();
		// restart mid-circle, centered on the last visible pixel
		send_request(CMD_START, 16'd1023, 16'd767, 16'd2, 8'h81);
		repeat (3) step_request();
		send_request(CMD_START, 16'h8000, 16'h7FFF, 16'h8000, 8'h7F);
		repeat (2) step_request();
		drain();

		// screen-size phases: zero width, zero height, 1x1, 4096x4096, all-ones, typical
		for (int ph = 0; ph < 6; ph++) begin
			set_screen(RES_W'(phase_w[ph]), RES_W'(phase_h[ph]));
			stall_pct = phase_st[ph];
			gap_pct   = phase_gp[ph];
			if (ph == 3)
				hold_off = 1'b1;
			random_circles(PHASE_ITEMS);
			drain();
		end
		set_screen(RES_W'($urandom_range(1, 8191)), RES_W'($urandom_range(1, 8191)));
		stall_pct = 35;
		gap_pct   = 35;
		random_circles(PHASE_ITEMS);
		drain();

		$display("Sent %0d requests (%0d starts or pixel steps); %0d steps drew, %0d circles closed.",
			total_requests, counted_items, sb.steps_taken, sb.circles_closed);
		$display("Checked %0d pixels, %0d off screen, over 8 screen sizes; %0d mismatches.",
			sb.pixels_checked, sb.hidden_pixels, sb.mismatches);
		if (sb.mismatches == 0 && sb.pixel_fifo.size() == 0)
			$display("midpoint_circle_rasterizer_tb OK");
		else
			$display("midpoint_circle_rasterizer_tb NOT OK");
		$finish;
	end

endmodule
